[hw/rtl/phone_record_sorter_unit_defines.svh]
// Assertion macros used by the checker file of the phone record sorter.
`ifndef PHONE_RECORD_SORTER_UNIT_DEFINES_SVH
`define PHONE_RECORD_SORTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PRS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("phone record sorter: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define PRS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("phone record sorter: next-cycle check failed");

`endif

[hw/rtl/prs_pkg.sv]
// Package with sizes, key types and link types of the phone record sorter.
package prs_pkg;

  localparam int MAX_RECORDS  = 64;
  localparam int AREA_CHARS   = 3;
  localparam int NUMBER_CHARS = 8;

  localparam int AREA_W   = 24;
  localparam int NUMBER_W = 64;
  localparam int CNT_W    = $clog2(MAX_RECORDS + 1);

  // Only the low character bytes take part in the key.
  localparam logic [AREA_W-1:0] AREA_MASK =
    {AREA_W{1'b1}} >> (AREA_W - 8 * AREA_CHARS);
  localparam logic [NUMBER_W-1:0] NUMBER_MASK =
    {NUMBER_W{1'b1}} >> (NUMBER_W - 8 * NUMBER_CHARS);

  // Compound key: area code in the upper bits, so one unsigned compare orders both.
  typedef struct packed {
    logic [AREA_W-1:0]   area;
    logic [NUMBER_W-1:0] number;
  } key_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic valid;
    logic lt;
    key_t key;
  } link_t;

  // Chain-wide commands.
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

[hw/rtl/prs_cell.sv]
// One cell of the insertion-sort chain: holds one record and its valid bit.
module prs_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  prs_pkg::cell_ctrl_t ctrl,
  input  prs_pkg::key_t       new_key,
  input  prs_pkg::link_t      prev,
  input  prs_pkg::link_t      next,
  output prs_pkg::link_t      link_o
);

  logic          valid_r;
  logic          valid_nxt;
  prs_pkg::key_t key_r;
  prs_pkg::key_t key_nxt;
  logic          lt;

  // The new record belongs at or before this cell when the cell is empty or larger.
  assign lt = !valid_r || (new_key < key_r);

  assign link_o = '{valid: valid_r, lt: lt, key: key_r};

  // Insert: the first cell that is larger takes the new record, the ones after it
  // move up by one. Shift: every cell takes its right neighbor for readout.
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    if (ctrl.shift) begin
      valid_nxt = next.valid;
      key_nxt   = next.key;
    end else if (ctrl.insert && lt) begin
      if (prev.lt) begin
        valid_nxt = prev.valid;
        key_nxt   = prev.key;
      end else begin
        valid_nxt = 1'b1;
        key_nxt   = new_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    key_r <= key_nxt;
  end

endmodule

[hw/rtl/phone_record_sorter_unit.sv]
// Top level of the phone record sorter: cell chain plus load and readout control.
//
//   channel  ports                                   handshake
//   input    in_area_code, in_phone_number,          start & !busy
//            in_final_record
//   result   out_sorted_area_code,                   out_valid, one cycle
//            out_sorted_phone_number,
//            out_last_of_run, out_records_dropped
//
// While busy is low a request is placed in the chain at once if it has room, else it is dropped.
// After the final request the chain shifts out one record a cycle from its first
// cell while busy is high; results appear in the cycle after, back to back.
// Reset is synchronous and empties the chain.
// The receiver cannot stall; results are never held.
module phone_record_sorter_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [prs_pkg::AREA_W-1:0]    in_area_code,
  input  logic [prs_pkg::NUMBER_W-1:0]  in_phone_number,
  input  logic                          in_final_record,
  output logic                          out_valid,
  output logic [prs_pkg::AREA_W-1:0]    out_sorted_area_code,
  output logic [prs_pkg::NUMBER_W-1:0]  out_sorted_phone_number,
  output logic                          out_last_of_run,
  output logic                          out_records_dropped
);

  localparam logic [prs_pkg::CNT_W-1:0] CNT_FULL = prs_pkg::CNT_W'(prs_pkg::MAX_RECORDS);
  localparam logic [prs_pkg::CNT_W-1:0] CNT_ONE  = prs_pkg::CNT_W'(1);

  logic                       accept;
  logic                       room;
  prs_pkg::key_t              new_key;
  prs_pkg::cell_ctrl_t        ctrl;
  prs_pkg::link_t             links [prs_pkg::MAX_RECORDS];

  logic [prs_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic                       overflow_r, overflow_nxt;
  logic                       drain_r, drain_nxt;
  logic [prs_pkg::CNT_W-1:0]  remain_r, remain_nxt;
  logic                       dropped_r, dropped_nxt;
  logic                       out_valid_r;
  prs_pkg::key_t              out_key_r;
  logic                       out_last_r;
  logic                       out_dropped_r;

  assign busy   = drain_r;
  assign accept = start && !drain_r;
  assign room   = (count_r < CNT_FULL);

  assign new_key = '{area: in_area_code & prs_pkg::AREA_MASK,
                     number: in_phone_number & prs_pkg::NUMBER_MASK};

  assign ctrl = '{insert: accept && room, shift: drain_r};

  // The chain of cells; the ends see an empty neighbor that never takes a record.
  for (genvar i = 0; i < prs_pkg::MAX_RECORDS; i++) begin : g_cell
    prs_pkg::link_t prev_link;
    prs_pkg::link_t next_link;
    if (i == 0) begin : g_first
      assign prev_link = '0;
    end else begin : g_mid_prev
      assign prev_link = links[i-1];
    end
    if (i == prs_pkg::MAX_RECORDS - 1) begin : g_last
      assign next_link = '0;
    end else begin : g_mid_next
      assign next_link = links[i+1];
    end
    prs_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .new_key (new_key),
      .prev    (prev_link),
      .next    (next_link),
      .link_o  (links[i])
    );
  end

  // Load counting, overflow tracking, the switch to readout and its countdown.
  always_comb begin
    count_nxt    = count_r;
    overflow_nxt = overflow_r;
    drain_nxt    = drain_r;
    remain_nxt   = remain_r;
    dropped_nxt  = dropped_r;
    if (drain_r) begin
      remain_nxt = remain_r - CNT_ONE;
      if (remain_r == CNT_ONE) begin
        drain_nxt = 1'b0;
      end
    end else if (accept) begin
      if (room) begin
        count_nxt = count_r + CNT_ONE;
      end else begin
        overflow_nxt = 1'b1;
      end
      if (in_final_record) begin
        drain_nxt    = 1'b1;
        remain_nxt   = count_nxt;
        dropped_nxt  = overflow_nxt;
        count_nxt    = '0;
        overflow_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      overflow_r  <= 1'b0;
      drain_r     <= 1'b0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      overflow_r  <= overflow_nxt;
      drain_r     <= drain_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= drain_r;
    end
    dropped_r     <= dropped_nxt;
    out_key_r     <= links[0].key;
    out_last_r    <= (remain_r == CNT_ONE);
    out_dropped_r <= dropped_r;
  end

  assign out_valid               = out_valid_r;
  assign out_sorted_area_code    = out_key_r.area;
  assign out_sorted_phone_number = out_key_r.number;
  assign out_last_of_run         = out_last_r;
  assign out_records_dropped     = out_dropped_r;

endmodule

[hw/rtl/prs_checker.sv]
// Port-level checker for the phone record sorter and its bind to the top level.
`include "phone_record_sorter_unit_defines.svh"

module prs_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_final_record,
  input logic out_valid,
  input logic out_last_of_run
);

  // A final request always starts a readout.
  `PRS_ASSERT_NEXT(a_final_starts_run, clk, rst_n, start && !busy && in_final_record, busy)

  // Results only follow a cycle in which the block was reading out.
  `PRS_ASSERT_NOW(a_result_after_busy, clk, rst_n, out_valid, $past(busy))

  // A run is contiguous until its last result.
  `PRS_ASSERT_NEXT(a_run_contiguous, clk, rst_n, out_valid && !out_last_of_run, out_valid)

  // Nothing follows directly after the last result of a run.
  `PRS_ASSERT_NEXT(a_run_ends, clk, rst_n, out_valid && out_last_of_run, !out_valid)

endmodule

bind phone_record_sorter_unit prs_checker u_prs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_final_record (in_final_record),
  .out_valid       (out_valid),
  .out_last_of_run (out_last_of_run)
);
